FILE: src/vtdi_pkg.sv
// Types and constants shared by the vertex triple deduplication indexer.
// No dependencies.

package vtdi_pkg;

    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned REC_FLOATS = 8;
    localparam int unsigned POS_FLOATS = 3;
    localparam int unsigned TEX_FLOATS = 2;
    localparam int unsigned NRM_FLOATS = 3;

    typedef struct packed {
        logic [FIELD_BITS-1:0] position_index;
        logic [FIELD_BITS-1:0] texcoord_index;
        logic [FIELD_BITS-1:0] normal_index;
        logic                  last_of_mesh;
    } item_t;

    typedef struct packed {
        logic [8:0]  vertex_index;
        logic        is_new;
        logic        table_full;
        logic [8:0]  unique_count;
        logic [17:0] position_address;
        logic [16:0] texcoord_address;
        logic [17:0] normal_address;
        logic [10:0] slot_address;
    } result_t;

endpackage

FILE: src/vertex_triple_dedup_indexer.sv
// Top level of the vertex triple deduplication indexer.
// Depends on vtdi_pkg for the item and result types and the stride constants.
//
// Usage:
//   An item (position, texcoord and normal index plus last_of_mesh) is taken
//   on a rising edge with start high and busy low. busy stays high while the
//   stored triples are scanned, one entry a cycle through a single comparator
//   fed by the table memory's registered read port.
//   Each item gives one result, shown on result for exactly one cycle with
//   done high; the receiver cannot stall it, so it must take it then.
//   A miss ends the search once all N stored triples have been compared; a
//   hit at entry k (from 0) ends it once entry k has been compared. A search
//   covers at most MAX_UNIQUE entries, as the scan takes them in turn.
//   A new item may be started in the cycle that done is high.
//   A miss appends the triple; with the table full it returns index 0 and
//   sets table_full. last_of_mesh empties the table after its result.
//   Reset clears the stored count; table contents need no clearing since
//   only entries below the count are ever compared.

module vertex_triple_dedup_indexer #(
    parameter int MAX_UNIQUE = 256,
    parameter int INDEX_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vtdi_pkg::item_t   item,
    output logic              done,
    output vtdi_pkg::result_t result
);
    import vtdi_pkg::*;

    localparam int CW = $clog2(MAX_UNIQUE + 1);
    localparam int AW = $clog2(MAX_UNIQUE);
    localparam int TW = 3 * INDEX_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [AW-1:0] cmp_reg, cmp_next;
    logic          pend_reg, pend_next;
    logic          last_reg, last_next;
    logic [TW-1:0] triple_reg, triple_next;
    logic          done_reg, done_next;
    result_t       res_reg, res_next;

    logic [TW-1:0] mem [MAX_UNIQUE];
    logic [TW-1:0] rd_data_reg;
    logic          wr_en;

    logic [INDEX_BITS-1:0] p_idx, t_idx, n_idx;
    logic [17:0]           p18, n18;
    logic [16:0]           t17;
    logic [CW-1:0]         vidx;
    logic [10:0]           vm1;
    logic                  hit;

    assign p_idx = INDEX_BITS'(item.position_index);
    assign t_idx = INDEX_BITS'(item.texcoord_index);
    assign n_idx = INDEX_BITS'(item.normal_index);
    assign p18   = 18'(p_idx);
    assign t17   = 17'(t_idx);
    assign n18   = 18'(n_idx);

    assign hit = pend_reg && (rd_data_reg == triple_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= triple_reg;
        end
        rd_data_reg <= mem[scan_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        cmp_next    = cmp_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        triple_next = triple_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        wr_en       = 1'b0;
        vidx        = '0;
        vm1         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    triple_next = {p_idx, t_idx, n_idx};
                    last_next   = item.last_of_mesh;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SEARCH;
                    res_next.position_address = (p18 == '0) ? '0
                        : (p18 - 18'd1) * 18'(POS_FLOATS);
                    res_next.texcoord_address = (t17 == '0) ? '0
                        : (t17 - 17'd1) * 17'(TEX_FLOATS);
                    res_next.normal_address   = (n18 == '0) ? '0
                        : (n18 - 18'd1) * 18'(NRM_FLOATS);
                end
            end
            S_SEARCH:
            begin
                priority if (hit)
                begin
                    vidx                  = CW'(cmp_reg) + CW'(1);
                    vm1                   = 11'(cmp_reg);
                    res_next.vertex_index = 9'(vidx);
                    res_next.is_new       = 1'b0;
                    res_next.table_full   = 1'b0;
                    res_next.unique_count = 9'(count_reg);
                    res_next.slot_address = 11'(vm1 * 11'(REC_FLOATS));
                    count_next            = last_reg ? '0 : count_reg;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else if (scan_reg < count_reg)
                begin
                    cmp_next  = scan_reg[AW-1:0];
                    pend_next = 1'b1;
                    scan_next = scan_reg + CW'(1);
                end
                else
                begin
                    if (count_reg < CW'(MAX_UNIQUE))
                    begin
                        wr_en                 = 1'b1;
                        vidx                  = count_reg + CW'(1);
                        vm1                   = 11'(count_reg);
                        res_next.vertex_index = 9'(vidx);
                        res_next.is_new       = 1'b1;
                        res_next.table_full   = 1'b0;
                        res_next.unique_count = 9'(vidx);
                        res_next.slot_address = 11'(vm1 * 11'(REC_FLOATS));
                        count_next            = last_reg ? '0 : vidx;
                    end
                    else
                    begin
                        res_next.vertex_index = '0;
                        res_next.is_new       = 1'b0;
                        res_next.table_full   = 1'b1;
                        res_next.unique_count = 9'(count_reg);
                        res_next.slot_address = '0;
                        count_next            = last_reg ? '0 : count_reg;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg    <= cmp_next;
        last_reg   <= last_next;
        triple_reg <= triple_next;
        res_reg    <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while still searching");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start a search");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_UNIQUE))
        else $error("stored count beyond table depth");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |->
            (result.vertex_index == '0 && !result.is_new))
        else $error("overflow result carries an index");

    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_new) |-> (result.vertex_index == result.unique_count))
        else $error("new vertex index differs from stored count");

endmodule
